// File: hdl/rational_reduce_and_compare_core_assert.svh
// Assertion macros for the rational reduce and compare core
`ifndef RATIONAL_REDUCE_AND_COMPARE_CORE_ASSERT_SVH
`define RATIONAL_REDUCE_AND_COMPARE_CORE_ASSERT_SVH
// implication check on the rising clock, reset disables
`define RRC_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("rrc check failed");
// next-cycle implication check
`define RRC_ASSERT_NXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("rrc check failed");
`endif

// File: hdl/rrc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrc_pkg
// Shared widths of the request, result and flag fields.
// ---------------------------------------------------------------------------
package rrc_pkg;
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned DEN_W = 31;
	localparam int unsigned IN_W = 4 * FIELD_W;
	localparam int unsigned OUT_W = 2 * FIELD_W + 2 * DEN_W;
	localparam int unsigned OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
	localparam int unsigned FLAG_W = 3;
	localparam int unsigned FLAG_BYTES_W = 8;
endpackage

// File: hdl/rrc_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrc_lane
// Reduce one fraction: binary GCD, then two restoring divisions by it.
// ---------------------------------------------------------------------------
module rrc_lane #(
	parameter int unsigned W = rrc_pkg::VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-2:0] num_mag,
	input  logic [W-2:0] den_mag,
	output logic         done,
	output logic [W-2:0] num_red,
	output logic [W-2:0] den_red
);
	import rrc_pkg::*;

	localparam int unsigned M = W - 1;
	localparam int unsigned CW = $clog2(M + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_GCD, ST_SHIFT, ST_DIVN, ST_DIVD, ST_DONE} state_t;

	state_t        state_q;
	logic [M-1:0]  a_q, b_q, g_q, quo_q, dvd_q;
	logic [M-1:0]  num_q, den_q;
	logic [M:0]    rem_q;
	logic [CW-1:0] sh_q, cnt_q;
	logic [M:0]    trial;
	logic [M-1:0]  diff;

	assign trial = {rem_q[M-1:0], dvd_q[M-1]} - {1'b0, g_q};
	assign diff = (a_q > b_q) ? a_q - b_q : b_q - a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q <= num_mag;
						b_q <= den_mag;
						num_q <= num_mag;
						den_q <= den_mag;
						sh_q <= '0;
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					if (a_q == b_q) begin
						g_q <= a_q;
						state_q <= ST_SHIFT;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (a_q > b_q) begin
						a_q <= diff >> 1;
					end else begin
						b_q <= diff >> 1;
					end
				end
				ST_SHIFT: begin
					if (sh_q != '0) begin
						g_q <= g_q << 1;
						sh_q <= sh_q - 1'b1;
					end else begin
						dvd_q <= num_q;
						rem_q <= '0;
						cnt_q <= CW'(M);
						state_q <= ST_DIVN;
					end
				end
				ST_DIVN, ST_DIVD: begin
					dvd_q <= dvd_q << 1;
					if (!trial[M]) begin
						rem_q <= trial;
						quo_q <= {quo_q[M-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[M-1:0], dvd_q[M-1]};
						quo_q <= {quo_q[M-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						if (state_q == ST_DIVN) begin
							num_red <= trial[M] ? {quo_q[M-2:0], 1'b0} : {quo_q[M-2:0], 1'b1};
							dvd_q <= den_q;
							rem_q <= '0;
							cnt_q <= CW'(M);
							state_q <= ST_DIVD;
						end else begin
							den_red <= trial[M] ? {quo_q[M-2:0], 1'b0} : {quo_q[M-2:0], 1'b1};
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/rrc_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrc_merge
// Combine lane results: signs, cross products, compare, output register.
// ---------------------------------------------------------------------------
module rrc_merge #(
	parameter int unsigned W = rrc_pkg::VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic         bad,
	input  logic         lneg,
	input  logic         rneg,
	input  logic [W-2:0] ln,
	input  logic [W-2:0] ld,
	input  logic [W-2:0] rn,
	input  logic [W-2:0] rd,
	input  logic         out_ready,
	output logic         busy,
	output logic         out_valid,
	output logic [rrc_pkg::OUT_BYTES_W-1:0] out_data,
	output logic [rrc_pkg::FLAG_BYTES_W-1:0] out_user
);
	import rrc_pkg::*;

	localparam int unsigned M = W - 1;

	logic               go_s1, bad_s1, lneg_s1, rneg_s1;
	logic [M-1:0]       ln_s1, ld_s1, rn_s1, rd_s1;
	logic [2*M-1:0]     lx_s1, rx_s1;
	logic signed [FIELD_W-1:0] lsn, rsn;
	logic               lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			bad_s1 <= bad;
			lneg_s1 <= lneg && (ln != '0);
			rneg_s1 <= rneg && (rn != '0);
			ln_s1 <= ln;
			rn_s1 <= rn;
			ld_s1 <= (ln == '0) ? M'(1) : ld;
			rd_s1 <= (rn == '0) ? M'(1) : rd;
			lx_s1 <= ln * ((rn == '0) ? M'(1) : rd);
			rx_s1 <= rn * ((ln == '0) ? M'(1) : ld);
		end
	end

	assign lsn = lneg_s1 ? -FIELD_W'(ln_s1) : FIELD_W'(ln_s1);
	assign rsn = rneg_s1 ? -FIELD_W'(rn_s1) : FIELD_W'(rn_s1);
	always_comb begin
		if (lneg_s1 != rneg_s1) lt = lneg_s1;
		else if (lneg_s1) lt = lx_s1 > rx_s1;
		else lt = lx_s1 < rx_s1;
	end

	assign busy = go_s1 || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_data <= '0;
			out_user <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (go_s1) begin
				out_valid <= 1'b1;
				if (bad_s1) begin
					out_data <= '0;
					out_user <= FLAG_BYTES_W'(3'b100);
				end else begin
					out_data <= OUT_BYTES_W'({DEN_W'(rd_s1), rsn, DEN_W'(ld_s1), lsn});
					out_user <= FLAG_BYTES_W'({1'b0,
						(lsn == rsn) && (ld_s1 == rd_s1), lt});
				end
			end
		end
	end
endmodule

// File: hdl/rational_reduce_and_compare_core.sv
`timescale 1ns / 1ps
// Timing: a bad input skips both lanes and a zero numerator skips its own lane;
// otherwise each lane runs its GCD loop, then two divider passes, before the merge stage.
// Throughput: one request at a time; the next is taken only after the result has left.
// Reset: arst_n clears the lane sequencers and the output valid.
// ---------------------------------------------------------------------------
// rational_reduce_and_compare_core
// Two lanes reduce the two fractions in parallel; a merge stage compares.
// ---------------------------------------------------------------------------
module rational_reduce_and_compare_core #(
	parameter int unsigned VALUE_WIDTH = rrc_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// lhs_num, lhs_den, rhs_num, rhs_den
	input  logic [rrc_pkg::IN_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// lhs_num_reduced, lhs_den_reduced, rhs_num_reduced, rhs_den_reduced, pad
	output logic [rrc_pkg::OUT_BYTES_W-1:0] m_axis_tdata,
	// less_than, equal, bad_input, pad
	output logic [rrc_pkg::FLAG_BYTES_W-1:0] m_axis_tuser
);
	import rrc_pkg::*;
	`include "rational_reduce_and_compare_core_assert.svh"

	localparam int unsigned M = VALUE_WIDTH - 1;

	logic [VALUE_WIDTH-1:0] v [4];
	logic [M-1:0] mag [4];
	logic         bad, busy_q, go, mbusy, ldone, rdone, lfin_q, rfin_q;
	logic         bad_q, lneg_q, rneg_q;
	logic [M-1:0] ln, ld, rn, rd;
	logic         acc;
	logic         sent_q;

	for (genvar i = 0; i < 4; i++) begin : g_in
		assign v[i] = s_axis_tdata[i*FIELD_W +: VALUE_WIDTH];
		assign mag[i] = v[i][VALUE_WIDTH-1] ? M'(-v[i]) : v[i][M-1:0];
	end

	always_comb begin
		bad = (v[1] == '0) || (v[3] == '0);
		for (int i = 0; i < 4; i++)
			if (v[i] == {1'b1, {M{1'b0}}}) bad = 1'b1;
	end

	assign s_axis_tready = !busy_q;
	assign acc = s_axis_tvalid && s_axis_tready;

	rrc_lane #(.W(VALUE_WIDTH)) u_lane_l (
		.clk(clk), .arst_n(arst_n), .start(acc && !bad && mag[0] != '0),
		.num_mag(mag[0]), .den_mag(mag[1]), .done(ldone), .num_red(ln), .den_red(ld));
	rrc_lane #(.W(VALUE_WIDTH)) u_lane_r (
		.clk(clk), .arst_n(arst_n), .start(acc && !bad && mag[2] != '0),
		.num_mag(mag[2]), .den_mag(mag[3]), .done(rdone), .num_red(rn), .den_red(rd));

	logic lzero_q, rzero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lfin_q <= 1'b0;
			rfin_q <= 1'b0;
			bad_q <= 1'b0;
			lneg_q <= 1'b0;
			rneg_q <= 1'b0;
			lzero_q <= 1'b0;
			rzero_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
				bad_q <= bad;
				lneg_q <= v[0][VALUE_WIDTH-1] ^ v[1][VALUE_WIDTH-1];
				rneg_q <= v[2][VALUE_WIDTH-1] ^ v[3][VALUE_WIDTH-1];
				lzero_q <= mag[0] == '0;
				rzero_q <= mag[2] == '0;
				lfin_q <= bad || mag[0] == '0;
				rfin_q <= bad || mag[2] == '0;
			end else begin
				if (ldone) lfin_q <= 1'b1;
				if (rdone) rfin_q <= 1'b1;
				if (go) begin
					lfin_q <= 1'b0;
					rfin_q <= 1'b0;
				end
				if (sent_q && !mbusy) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sent_q <= 1'b0;
		else if (acc) sent_q <= 1'b0;
		else if (go) sent_q <= 1'b1;
	end

	assign go = busy_q && lfin_q && rfin_q && !sent_q;

	rrc_merge #(.W(VALUE_WIDTH)) u_merge (
		.clk(clk), .arst_n(arst_n), .go(go), .bad(bad_q), .lneg(lneg_q), .rneg(rneg_q),
		.ln(lzero_q ? '0 : ln), .ld(ld), .rn(rzero_q ? '0 : rn), .rd(rd),
		.out_ready(m_axis_tready), .busy(mbusy), .out_valid(m_axis_tvalid),
		.out_data(m_axis_tdata), .out_user(m_axis_tuser));

	`RRC_ASSERT_IMP(a_no_accept_busy, busy_q && !sent_q, !s_axis_tready)
	`RRC_ASSERT_NXT(a_go_once, go, !go)
	`RRC_ASSERT_IMP(a_bad_zero, m_axis_tvalid && m_axis_tuser[2], m_axis_tdata == '0)
endmodule

// File: tb/rrc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrc_checker
// Watches both stream channels of the fraction reduce and compare core.
// For each accepted request it computes the reduced fractions, the less-than
// and equality flags and the bad-input flag, then compares each result in
// order, field by field.
// ---------------------------------------------------------------------------
module rrc_checker #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [rrc_pkg::IN_W-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [rrc_pkg::OUT_BYTES_W-1:0] m_axis_tdata,
	input  logic [rrc_pkg::FLAG_BYTES_W-1:0] m_axis_tuser,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic [31:0] lnum;
		logic [30:0] lden;
		logic [31:0] rnum;
		logic [30:0] rden;
		logic less;
		logic eq;
		logic bad;
	} fraction_result_t;

	fraction_result_t expect_mem [64];
	logic [5:0] wr_q, rd_q;

	function automatic longint sext_field(logic [31:0] raw);
		longint v;
		v = raw & ((64'd1 << VALUE_WIDTH) - 1);
		if (v[VALUE_WIDTH-1])
			v = v - (64'sd1 <<< VALUE_WIDTH);
		return v;
	endfunction

	function automatic longint gcd_of(longint a, longint b);
		longint t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic void lowest_terms(input longint n, input longint d,
			output longint rn, output longint rd);
		longint an, ad, g;
		bit neg;
		neg = (n < 0) != (d < 0);
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		if (an == 0) begin
			rn = 0;
			rd = 1;
		end else begin
			g = gcd_of(an, ad);
			an = an / g;
			ad = ad / g;
			rn = neg ? -an : an;
			rd = ad;
		end
	endfunction

	function automatic fraction_result_t reduce_pair(logic [rrc_pkg::IN_W-1:0] req);
		fraction_result_t r;
		longint v[4];
		longint most_neg, ln, ld, rn, rd;
		r = '0;
		most_neg = -(64'sd1 <<< (VALUE_WIDTH - 1));
		for (int i = 0; i < 4; i++)
			v[i] = sext_field(req[32*i +: 32]);
		if (v[0] == most_neg || v[1] == most_neg || v[2] == most_neg ||
				v[3] == most_neg || v[1] == 0 || v[3] == 0) begin
			r.bad = 1'b1;
			return r;
		end
		lowest_terms(v[0], v[1], ln, ld);
		lowest_terms(v[2], v[3], rn, rd);
		r.lnum = ln[31:0];
		r.lden = ld[30:0];
		r.rnum = rn[31:0];
		r.rden = rd[30:0];
		r.less = (ln * rd) < (rn * ld);
		r.eq = (ln == rn) && (ld == rd);
		return r;
	endfunction

	assign pending = int'(6'(wr_q - rd_q));

	always @(posedge clk or negedge arst_n) begin
		fraction_result_t want, got;
		if (!arst_n) begin
			errors <= 0;
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expect_mem[wr_q] <= reduce_pair(s_axis_tdata);
				wr_q <= wr_q + 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.lnum = m_axis_tdata[31:0];
				got.lden = m_axis_tdata[62:32];
				got.rnum = m_axis_tdata[94:63];
				got.rden = m_axis_tdata[125:95];
				got.less = m_axis_tuser[0];
				got.eq = m_axis_tuser[1];
				got.bad = m_axis_tuser[2];
				if (wr_q == rd_q) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = expect_mem[rd_q];
					rd_q <= rd_q + 1'b1;
					if (want != got) begin
						$display("%0t: mismatch expected num %0d/%0d %0d/%0d lt %b eq %b bad %b",
							$time, $signed(want.lnum), want.lden, $signed(want.rnum),
							want.rden, want.less, want.eq, want.bad);
						$display("%0t:          actual num %0d/%0d %0d/%0d lt %b eq %b bad %b",
							$time, $signed(got.lnum), got.lden, $signed(got.rnum),
							got.rden, got.less, got.eq, got.bad);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives fraction pairs into the reduce and compare core with random gaps
// and output stalls; a checker beside the core predicts every result.
// ---------------------------------------------------------------------------
module testbench;
	localparam int RANDOM_ITEMS = 850;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [rrc_pkg::IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [rrc_pkg::OUT_BYTES_W-1:0] m_axis_tdata;
	logic [rrc_pkg::FLAG_BYTES_W-1:0] m_axis_tuser;
	int errors;
	int pending;
	int idle_cycles;
	bit calm;

	rational_reduce_and_compare_core u_dut (.*);

	rrc_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// stall the result side in bursts
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 18);
				m_axis_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			n = $urandom_range(1, 30);
			repeat (n - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_request(logic [31:0] ln, logic [31:0] ld, logic [31:0] rn,
			logic [31:0] rd);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_axis_tdata <= {rd, rn, ld, ln};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 40) - 20;
			1: return $urandom_range(1, 1000) * ($urandom_range(0, 1) ? 1 : -1);
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
			3: return 32'h7fffffff - $urandom_range(0, 3);
			4: return 32'h80000000 + $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] g, a, b;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_cycles = 0;
		calm = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_request(0, 5, 0, -7);
		send_request(6, 4, 3, 2);
		send_request(-6, 4, 3, -2);
		send_request(1, 3, 1, 2);
		send_request(1, 2, 1, 3);
		send_request(5, 0, 1, 1);
		send_request(1, 1, 5, 0);
		send_request(32'h80000000, 1, 1, 1);
		send_request(1, 32'h80000000, 1, 1);
		send_request(1, 1, 32'h80000000, 1);
		send_request(1, 1, 1, 32'h80000000);
		send_request(32'h7fffffff, 1, 32'h80000001, 1);
		send_request(32'h7fffffff, 32'h7fffffff, 1, 1);
		send_request(32'h7fffffff, 32'h7ffffffe, 32'h7ffffffe, 32'h7ffffffd);
		send_request(32'h80000001, 32'h7fffffff, -1, 32'h80000001);
		send_request(-1, 32'h7fffffff, 1, 32'h80000001);
		send_request(32'hffffffff, 32'hffffffff, 1, 1);
		send_request(0, 32'hffffffff, 0, 1);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > RANDOM_ITEMS - 100)
				calm = 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				g = $urandom_range(1, 50000);
				a = $urandom_range(0, 40000) - 20000;
				b = $urandom_range(1, 40000) * ($urandom_range(0, 1) ? 1 : -1);
				send_request(a * g, b * g, random_value(), random_value());
			end else if ($urandom_range(0, 3) == 0) begin
				a = random_value();
				b = random_value();
				g = $urandom_range(1, 5);
				send_request(a, b, a * g, b * g);
			end else begin
				send_request(random_value(), random_value(), random_value(), random_value());
			end
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b1;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
